>>> rtl/core/smdc_pkg.sv
package smdc_pkg;

    localparam int OPERAND_WIDTH_DEF = 64;
    localparam int PROD_W            = 128;
    localparam int CFG_IDX_W         = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MIN_CAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MAX       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MAX_CAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNSIGNED_MAX_CAP = 3'd4;

    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL64  = 64'hFFFF_FFFF_FFFF_FFFF;

    // data carried along the divider chain
    typedef struct packed {
        logic         vld;
        logic         neg;
        logic [127:0] rem;
        logic [127:0] num;
        logic [127:0] quo;
        logic [63:0]  dvs;
    } div_token_t;

endpackage

>>> rtl/core/smdc_mul.sv
// Pipelined 64x64 magnitude multiplier built from four 32x32 partial products.
module smdc_mul #(
    parameter int OPERAND_WIDTH = smdc_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_vld,
    input  logic                    in_unsigned,
    input  logic [63:0]             in_a,
    input  logic [63:0]             in_b,
    input  logic [63:0]             in_z,
    output smdc_pkg::div_token_t    out_tok
);

    localparam logic [63:0] OP_MASK = smdc_pkg::ALL64 >> (64 - OPERAND_WIDTH);

    logic [63:0] a_mag, b_mag, z_mag;
    logic        na, nb, nz;

    // Take operand magnitudes, sign-extending from the operand width
    function automatic logic [64:0] mag(input logic [63:0] raw, input logic sgn);
        logic [63:0] v;
        v = raw & OP_MASK;
        if (sgn && v[OPERAND_WIDTH-1])
            mag = {1'b1, 64'd0 - (v | ~OP_MASK)};
        else
            mag = {1'b0, v};
    endfunction

    always_comb
    begin
        {na, a_mag} = mag(in_a, !in_unsigned);
        {nb, b_mag} = mag(in_b, !in_unsigned);
        {nz, z_mag} = mag(in_z, !in_unsigned);
    end

    // Stage 1: partial products
    logic        s1_vld_reg;
    logic        s1_neg_reg;
    logic [63:0] s1_z_reg;
    logic [63:0] ll_reg, lh_reg, hl_reg, hh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        s1_neg_reg <= na ^ nb ^ nz;
        s1_z_reg   <= z_mag;
        ll_reg     <= a_mag[31:0]  * b_mag[31:0];
        lh_reg     <= a_mag[31:0]  * b_mag[63:32];
        hl_reg     <= a_mag[63:32] * b_mag[31:0];
        hh_reg     <= a_mag[63:32] * b_mag[63:32];
    end

    // Stage 2: sum the partial products into the numerator
    logic        s2_vld_reg;
    logic        s2_neg_reg;
    logic [63:0] s2_z_reg;
    logic [127:0] prod_reg;
    logic [127:0] prod_next;

    assign prod_next = {64'd0, ll_reg} + {32'd0, lh_reg, 32'd0}
                     + {32'd0, hl_reg, 32'd0} + {hh_reg, 64'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_neg_reg <= s1_neg_reg;
        s2_z_reg   <= s1_z_reg;
        prod_reg   <= prod_next;
    end

    always_comb
    begin
        out_tok     = '0;
        out_tok.vld = s2_vld_reg;
        out_tok.neg = s2_neg_reg;
        out_tok.num = prod_reg;
        out_tok.dvs = s2_z_reg;
    end

endmodule

>>> rtl/core/smdc_div_cell.sv
// One restoring division step: shift one numerator bit in, subtract if it fits.
module smdc_div_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  smdc_pkg::div_token_t in_tok,
    output smdc_pkg::div_token_t out_tok
);

    smdc_pkg::div_token_t tok_reg, tok_next;
    logic                 vld_reg;
    logic [128:0]         shifted;
    logic                 fits;

    always_comb
    begin
        shifted  = {in_tok.rem, in_tok.num[127]};
        fits     = (shifted[128:64] != 65'd0) || (shifted[63:0] >= in_tok.dvs);
        tok_next = in_tok;
        tok_next.num = {in_tok.num[126:0], 1'b0};
        tok_next.rem = fits ? (shifted[127:0] - {64'd0, in_tok.dvs}) : shifted[127:0];
        tok_next.quo = {in_tok.quo[126:0], fits};
    end

    // Hold valid under reset, payload free-running
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= tok_next.vld;
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    always_comb
    begin
        out_tok     = tok_reg;
        out_tok.vld = vld_reg;
    end

endmodule

>>> rtl/core/smdc_clamp.sv
// Clamp stage: form the signed and unsigned views of the quotient.
module smdc_clamp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  smdc_pkg::div_token_t in_tok,
    input  logic [63:0]          signed_min,
    input  logic [63:0]          signed_min_cap,
    input  logic [62:0]          signed_max,
    input  logic [63:0]          signed_max_cap,
    input  logic [63:0]          unsigned_max_cap,
    output logic                 done,
    output logic                 quot_negative,
    output logic [63:0]          quot_upper,
    output logic [63:0]          quot_lower,
    output logic [63:0]          clamped_signed,
    output logic [63:0]          clamped_unsigned
);

    logic        done_reg;
    logic        neg_reg;
    logic [63:0] qhi_reg, qlo_reg, sres_reg, ures_reg;
    logic [63:0] sres_next, ures_next, negv;
    logic [63:0] qhi, qlo;
    logic        hi_nz;

    always_comb
    begin
        qhi   = in_tok.quo[127:64];
        qlo   = in_tok.quo[63:0];
        hi_nz = (qhi != 64'd0);
        negv  = 64'd0 - qlo;
        if (in_tok.neg)
        begin
            if (hi_nz || qlo > smdc_pkg::SIGN64)
                sres_next = signed_min_cap;
            else if ($signed(negv) < $signed(signed_min))
                sres_next = signed_min_cap;
            else
                sres_next = negv;
        end
        else if (hi_nz || qlo > {1'b0, signed_max})
            sres_next = signed_max_cap;
        else
            sres_next = qlo;

        if (in_tok.neg)
            ures_next = 64'd0;
        else if (hi_nz || qlo > unsigned_max_cap)
            ures_next = unsigned_max_cap;
        else
            ures_next = qlo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_tok.vld;
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= in_tok.neg;
        qhi_reg  <= qhi;
        qlo_reg  <= qlo;
        sres_reg <= sres_next;
        ures_reg <= ures_next;
    end

    assign done             = done_reg;
    assign quot_negative    = neg_reg;
    assign quot_upper       = qhi_reg;
    assign quot_lower       = qlo_reg;
    assign clamped_signed   = sres_reg;
    assign clamped_unsigned = ures_reg;

endmodule

>>> rtl/core/signed_muldiv_with_clamp_unit.sv
// Computes (mult_a * mult_b) / divisor at 128-bit width with signed or unsigned
// operands, then clamps the quotient. An operand set is taken on every cycle
// (busy is always low); its result appears on the outputs with done high
// after two multiplier stages, a chain of 128 division cells (one quotient
// bit each) and one clamp stage. The receiver cannot stall, so results must be
// captured in the cycle done is high.
module signed_muldiv_with_clamp_unit #(
    parameter int OPERAND_WIDTH = smdc_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           action,
    input  logic [63:0]                    mult_a,
    input  logic [63:0]                    mult_b,
    input  logic [63:0]                    divisor,
    output logic                           done,
    output logic                           quot_negative,
    output logic [63:0]                    quot_upper,
    output logic [63:0]                    quot_lower,
    output logic [63:0]                    clamped_signed,
    output logic [63:0]                    clamped_unsigned,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [smdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data
);

    localparam int NCELL = smdc_pkg::PROD_W;

    logic [63:0] signed_min_reg, signed_min_cap_reg, signed_max_cap_reg;
    logic [62:0] signed_max_reg;
    logic [63:0] unsigned_max_cap_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_min_reg       <= smdc_pkg::SIGN64;
            signed_min_cap_reg   <= smdc_pkg::SIGN64;
            signed_max_reg       <= smdc_pkg::ALL64[62:0];
            signed_max_cap_reg   <= smdc_pkg::SIGN64 - 64'd1;
            unsigned_max_cap_reg <= smdc_pkg::ALL64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                smdc_pkg::REG_SIGNED_MIN:       signed_min_reg       <= cfg_data;
                smdc_pkg::REG_SIGNED_MIN_CAP:   signed_min_cap_reg   <= cfg_data;
                smdc_pkg::REG_SIGNED_MAX:       signed_max_reg       <= cfg_data[62:0];
                smdc_pkg::REG_SIGNED_MAX_CAP:   signed_max_cap_reg   <= cfg_data;
                smdc_pkg::REG_UNSIGNED_MAX_CAP: unsigned_max_cap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    smdc_pkg::div_token_t chain [0:NCELL];

    smdc_mul #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_mul (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (start && !busy),
        .in_unsigned (action),
        .in_a        (mult_a),
        .in_b        (mult_b),
        .in_z        (divisor),
        .out_tok     (chain[0])
    );

    // Row of division cells, one quotient bit per cell
    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        smdc_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_tok  (chain[g]),
            .out_tok (chain[g+1])
        );
    end

    smdc_clamp u_clamp (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_tok           (chain[NCELL]),
        .signed_min       (signed_min_reg),
        .signed_min_cap   (signed_min_cap_reg),
        .signed_max       (signed_max_reg),
        .signed_max_cap   (signed_max_cap_reg),
        .unsigned_max_cap (unsigned_max_cap_reg),
        .done             (done),
        .quot_negative    (quot_negative),
        .quot_upper       (quot_upper),
        .quot_lower       (quot_lower),
        .clamped_signed   (clamped_signed),
        .clamped_unsigned (clamped_unsigned)
    );

    // An unsigned transaction never reports a negative quotient
    a_uns_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (start && action) |-> ##131 !quot_negative)
        else $error("unsigned transaction gave negative quotient");

    // Negative results never produce a nonzero unsigned view
    a_neg_uns: assert property (@(posedge clk) disable iff (!rst_n)
        (done && quot_negative) |-> (clamped_unsigned == 64'd0))
        else $error("negative quotient with nonzero unsigned result");

    // Every accepted transaction yields a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##131 done)
        else $error("result missing after pipeline latency");

endmodule
